@@ sv/pfr_pkg.sv @@
// Shared types and constants for the potential field repulsion sum unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int POS_W    = 32;
  localparam int AMAG_W   = 32;
  localparam int RAD_W    = 66;
  localparam int ROOT_W   = 33;
  localparam int RANGE_W  = 31;
  localparam int UNIT_W   = 17;
  localparam int HUGE_W   = 34;
  localparam int TERM_W   = HUGE_W + UNIT_W;
  localparam int OUT_W    = 48;
  localparam int CNT_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int IN_W     = 216;
  localparam int OUT_DW   = 168;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW   = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int LANES    = 4;

  localparam logic [HUGE_W-1:0] HUGE_MAG = 34'd10000000000;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_TEAM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd5;

  typedef struct packed {
    logic [RANGE_W-1:0] radius;
    logic [RANGE_W-1:0] min_range;
    logic               avoid;
    logic [15:0]        own_id;
    logic [7:0]         own_team;
    logic [GAIN_W-1:0]  gain;
  } cfg_t;

  typedef struct packed {
    logic                   keep;
    logic                   last;
    logic [2:0][AMAG_W-1:0] amag;
    logic [2:0]             neg;
    logic [RAD_W-1:0]       sumsq;
  } item_t;

endpackage

@@ sv/potential_field_repulsion_sum_unit.sv @@
// Potential field repulsion sum: top level with configuration registers.
// Front: an accepted contact takes three squaring steps and a push into the queue, and
// no new contact is taken until it is queued. Back end, per kept contact in range: pop,
// 33-step square root, check, divide, multiply, accumulate; out of range it ends at the
// check, a skipped one is only popped. A last contact adds scaling for each axis and emit.
// Reset (rst_n low, synchronous) loads register defaults and clears sums and queues.
`timescale 1ns / 1ps

module potential_field_repulsion_sum_unit import pfr_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // contact_id, contact_team, contact_x, contact_y, contact_z, self_x, self_y, self_z
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // force_x, force_y, force_z, saturated, contacts_used, zero pad
  output logic [OUT_DW-1:0]    out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  cfg_t  cfg_r;
  logic  push, full, fifo_valid, pop;
  item_t push_item, rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius    <= 31'd655360;
      cfg_r.min_range <= 31'd327680;
      cfg_r.avoid     <= 1'b1;
      cfg_r.own_id    <= 16'd0;
      cfg_r.own_team  <= 8'd0;
      cfg_r.gain      <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS:    cfg_r.radius    <= cfg_data[RANGE_W-1:0];
        REG_MIN_RANGE: cfg_r.min_range <= cfg_data[RANGE_W-1:0];
        REG_AVOID:     cfg_r.avoid     <= cfg_data[0];
        REG_OWN_ID:    cfg_r.own_id    <= cfg_data[15:0];
        REG_OWN_TEAM:  cfg_r.own_team  <= cfg_data[7:0];
        REG_GAIN:      cfg_r.gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  pfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg_r),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  pfr_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (push_item),
    .full    (full),
    .valid   (fifo_valid),
    .pop     (pop),
    .rd_item (rd_item)
  );

  pfr_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_valid (fifo_valid),
    .fifo_item  (rd_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sv/pfr_front.sv @@
// Front end: accepts contacts, classifies them and forms |diff| and squared distance.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_front import pfr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            in_tlast,
  input  cfg_t            cfg,
  output logic            push,
  output item_t           push_item,
  input  logic            full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQ   = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t        st_r, st_nxt;
  logic [1:0]     k_r, k_nxt;
  item_t          item_r, item_nxt;
  logic           accept;
  logic [63:0]    sq;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (st_r == F_IDLE);
  assign push_item = item_r;
  assign push      = (st_r == F_PUSH) && !full;
  assign sq        = item_r.amag[k_r] * item_r.amag[k_r];

  always_comb begin
    logic signed [POS_W:0] d;
    d        = '0;
    st_nxt   = st_r;
    k_nxt    = k_r;
    item_nxt = item_r;
    unique case (st_r)
      F_IDLE: begin
        if (accept) begin
          item_nxt.keep = (in_tdata[15:0] != cfg.own_id) &&
                          (cfg.avoid || (in_tdata[23:16] == cfg.own_team));
          item_nxt.last = in_tlast;
          item_nxt.sumsq = '0;
          for (int i = 0; i < 3; i++) begin
            d = {in_tdata[24+32*i+31], in_tdata[24+32*i +: 32]} -
                {in_tdata[120+32*i+31], in_tdata[120+32*i +: 32]};
            item_nxt.neg[i]  = !d[POS_W] && (d != '0);
            item_nxt.amag[i] = d[POS_W] ? AMAG_W'(-d) : d[AMAG_W-1:0];
          end
          k_nxt  = 2'd0;
          st_nxt = F_SQ;
        end
      end
      F_SQ: begin
        item_nxt.sumsq = item_r.sumsq + {2'b00, sq};
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) st_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      k_r  <= 2'd0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

@@ sv/pfr_fifo.sv @@
// Two-entry queue of classified contacts between front and back.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_fifo import pfr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  output logic  valid,
  input  logic  pop,
  output item_t rd_item
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  item_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [PTR_W:0]     cnt_r;

  assign full    = (cnt_r == (PTR_W+1)'(FIFO_DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_item = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ sv/pfr_div.sv @@
// Restoring divider lane: quotient of (num << 16) / den, one bit per cycle, 17 bits.
// Depends on pfr_pkg; the caller guarantees num >> 1 < den.
`timescale 1ns / 1ps

module pfr_div import pfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AMAG_W-1:0]  num,
  input  logic [RANGE_W-1:0] den,
  output logic               busy,
  output logic [UNIT_W-1:0]  quo
);

  logic [RANGE_W-1:0] den_r;
  logic [AMAG_W-1:0]  rem_r;
  logic [UNIT_W-1:0]  quo_r;
  logic               bit_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic [AMAG_W-1:0]  sh;

  assign busy = busy_r;
  assign quo  = quo_r;
  assign sh   = {rem_r[AMAG_W-2:0], bit_r};

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= {1'b0, num[AMAG_W-1:1]};
      bit_r <= num[0];
      quo_r <= '0;
    end else if (busy_r) begin
      bit_r <= 1'b0;
      if (sh >= {1'b0, den_r}) begin
        rem_r <= sh - {1'b0, den_r};
        quo_r <= {quo_r[UNIT_W-2:0], 1'b1};
      end else begin
        rem_r <= sh;
        quo_r <= {quo_r[UNIT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(UNIT_W - 1)) busy_r <= 1'b0;
    end
  end

endmodule

@@ sv/pfr_back.sv @@
// Back end: square root, direction and magnitude division, saturating accumulation,
// output scaling and the result register. Depends on pfr_pkg and pfr_div.
`timescale 1ns / 1ps

module pfr_back import pfr_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              fifo_valid,
  input  item_t             fifo_item,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata
);

  localparam int SUM_W = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 2;
  localparam int Q_W   = ACC_WIDTH - 8;
  localparam int QH_W  = Q_W - 28;
  localparam int P_W   = Q_W + GAIN_W;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic [P_W:0] LIM    = (P_W+1)'(1) << (OUT_W - 1);
  localparam logic [P_W:0] OUTMAX = LIM - 1'b1;

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_SQRT  = 9'b000000010,
    B_CHK   = 9'b000000100,
    B_DIV   = 9'b000001000,
    B_MUL   = 9'b000010000,
    B_ACC   = 9'b000100000,
    B_SC_LO = 9'b001000000,
    B_SC_HI = 9'b010000000,
    B_EMIT  = 9'b100000000
  } bstate_t;

  bstate_t                      st_r, st_nxt;
  item_t                        cur_r, cur_nxt;
  logic [RAD_W-1:0]             rad_r, rad_nxt;
  logic [ROOT_W-1:0]            root_r, root_nxt;
  logic [ROOT_W+2:0]            rem_r, rem_nxt;
  logic [5:0]                   sq_cnt_r, sq_cnt_nxt;
  logic                         inner_r, inner_nxt;
  logic [2:0][TERM_W-1:0]       t_r, t_nxt;
  logic [2:0][ACC_WIDTH-1:0]    sum_r, sum_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [CNT_W-1:0]             used_r, used_nxt;
  logic [1:0]                   ax_r, ax_nxt;
  logic [43:0]                  plo_r, plo_nxt;
  logic [2:0][OUT_W-1:0]        frc_r, frc_nxt;
  logic                         sat_r, sat_nxt;
  logic                         out_valid_r;
  logic [OUT_DW-1:0]            out_data_r;
  logic                         emit_fire;

  logic                         div_start;
  logic [LANES-1:0]             div_busy;
  logic [LANES-1:0][UNIT_W-1:0] quo;
  logic [LANES-1:0][AMAG_W-1:0] div_num;
  logic [LANES-1:0][RANGE_W-1:0] div_den;

  logic [ACC_WIDTH-1:0]         sel, mabs;
  logic [Q_W-1:0]               qv;

  assign pop        = (st_r == B_IDLE) && fifo_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign emit_fire  = (st_r == B_EMIT) && (!out_valid_r || out_tready);

  for (genvar g = 0; g < 3; g++) begin : g_unit
    assign div_num[g] = cur_r.amag[g];
    assign div_den[g] = root_r[RANGE_W-1:0];
  end
  assign div_num[3] = {1'b0, cfg.radius - root_r[RANGE_W-1:0]};
  assign div_den[3] = cfg.radius - cfg.min_range;

  for (genvar g = 0; g < LANES; g++) begin : g_div
    pfr_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (div_num[g]),
      .den   (div_den[g]),
      .busy  (div_busy[g]),
      .quo   (quo[g])
    );
  end

  assign sel  = sum_r[ax_r];
  assign mabs = sel[ACC_WIDTH-1] ? (~sel + 1'b1) : sel;
  assign qv   = mabs[ACC_WIDTH-1:8];

  always_comb begin
    logic [ROOT_W+2:0]       rem_sh, trial;
    logic signed [SUM_W-1:0] tex, acc_s;
    logic [QH_W+GAIN_W-1:0]  phi;
    logic [P_W-1:0]          prod;
    logic [23:0]             rmg_full;
    logic [P_W:0]            rr;
    logic                    clip;

    st_nxt     = st_r;
    cur_nxt    = cur_r;
    rad_nxt    = rad_r;
    root_nxt   = root_r;
    rem_nxt    = rem_r;
    sq_cnt_nxt = sq_cnt_r;
    inner_nxt  = inner_r;
    t_nxt      = t_r;
    sum_nxt    = sum_r;
    ovf_nxt    = ovf_r;
    used_nxt   = used_r;
    ax_nxt     = ax_r;
    plo_nxt    = plo_r;
    frc_nxt    = frc_r;
    sat_nxt    = sat_r;
    div_start  = 1'b0;
    rem_sh     = '0;
    trial      = '0;
    tex        = '0;
    acc_s      = '0;
    phi        = '0;
    prod       = '0;
    rmg_full   = '0;
    rr         = '0;
    clip       = 1'b0;

    unique case (st_r)
      B_IDLE: begin
        if (fifo_valid) begin
          cur_nxt = fifo_item;
          if (fifo_item.keep) begin
            rad_nxt    = fifo_item.sumsq;
            root_nxt   = '0;
            rem_nxt    = '0;
            sq_cnt_nxt = '0;
            st_nxt     = B_SQRT;
          end else if (fifo_item.last) begin
            ax_nxt  = 2'd0;
            sat_nxt = 1'b0;
            st_nxt  = B_SC_LO;
          end
        end
      end
      B_SQRT: begin
        // one root bit per cycle, two radicand bits shifted in
        rem_sh  = {rem_r[ROOT_W:0], rad_r[RAD_W-1:RAD_W-2]};
        trial   = {1'b0, root_r, 2'b01};
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        sq_cnt_nxt = sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'(ROOT_W - 1)) st_nxt = B_CHK;
      end
      B_CHK: begin
        if ((root_r != '0) && (root_r <= {2'b00, cfg.radius})) begin
          inner_nxt = (root_r <= {2'b00, cfg.min_range});
          div_start = 1'b1;
          st_nxt    = B_DIV;
        end else if (cur_r.last) begin
          ax_nxt  = 2'd0;
          sat_nxt = 1'b0;
          st_nxt  = B_SC_LO;
        end else begin
          st_nxt = B_IDLE;
        end
      end
      B_DIV: begin
        if (div_busy == '0) st_nxt = B_MUL;
      end
      B_MUL: begin
        for (int i = 0; i < 3; i++) begin
          if (inner_r) t_nxt[i] = HUGE_MAG * quo[i];
          else t_nxt[i] = TERM_W'(({17'd0, quo[3]} * {17'd0, quo[i]}) >> 16);
        end
        st_nxt = B_ACC;
      end
      B_ACC: begin
        ovf_nxt = ovf_r | inner_r;
        for (int i = 0; i < 3; i++) begin
          tex   = SUM_W'(t_r[i]);
          acc_s = SUM_W'(signed'(sum_r[i]));
          acc_s = cur_r.neg[i] ? (acc_s - tex) : (acc_s + tex);
          clip  = 1'b0;
          if (acc_s > ACC_MAX) begin
            acc_s = ACC_MAX;
            clip  = 1'b1;
          end else if (acc_s < ACC_MIN) begin
            acc_s = ACC_MIN;
            clip  = 1'b1;
          end
          sum_nxt[i] = acc_s[ACC_WIDTH-1:0];
          ovf_nxt    = ovf_nxt | clip;
        end
        if (used_r != '1) used_nxt = used_r + 1'b1;
        if (cur_r.last) begin
          ax_nxt  = 2'd0;
          sat_nxt = 1'b0;
          st_nxt  = B_SC_LO;
        end else begin
          st_nxt = B_IDLE;
        end
      end
      B_SC_LO: begin
        plo_nxt = qv[27:0] * cfg.gain;
        st_nxt  = B_SC_HI;
      end
      B_SC_HI: begin
        // q * gain above 2^47 is the same test as q > 2^47 / gain
        phi      = qv[Q_W-1:28] * cfg.gain;
        prod     = {phi, 28'b0} + P_W'(plo_r);
        rmg_full = mabs[7:0] * cfg.gain;
        if ({1'b0, prod} > LIM) rr = LIM;
        else rr = {1'b0, prod} + (P_W+1)'(rmg_full[23:8]);
        if (sel[ACC_WIDTH-1]) begin
          if (rr > LIM) begin
            rr      = LIM;
            sat_nxt = 1'b1;
          end
          frc_nxt[ax_r] = OUT_W'(~rr + 1'b1);
        end else begin
          if (rr > OUTMAX) begin
            rr      = OUTMAX;
            sat_nxt = 1'b1;
          end
          frc_nxt[ax_r] = OUT_W'(rr);
        end
        if (ax_r == 2'd2) begin
          st_nxt = B_EMIT;
        end else begin
          ax_nxt = ax_r + 2'd1;
          st_nxt = B_SC_LO;
        end
      end
      B_EMIT: begin
        if (emit_fire) begin
          sum_nxt  = '0;
          ovf_nxt  = 1'b0;
          used_nxt = '0;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sum_r  <= sum_nxt;
      ovf_r  <= ovf_nxt;
      used_r <= used_nxt;
      if (emit_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    rem_r    <= rem_nxt;
    sq_cnt_r <= sq_cnt_nxt;
    inner_r  <= inner_nxt;
    t_r      <= t_nxt;
    ax_r     <= ax_nxt;
    plo_r    <= plo_nxt;
    frc_r    <= frc_nxt;
    sat_r    <= sat_nxt;
    if (emit_fire)
      out_data_r <= {7'b0, used_r, ovf_r | sat_r, frc_r[2], frc_r[1], frc_r[0]};
  end

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_MUL) |-> (quo[0] <= 17'd65536 && quo[1] <= 17'd65536 &&
                         quo[2] <= 17'd65536))
    else $error("direction quotient above one");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_DIV && !div_busy[0]) |-> (div_busy == '0))
    else $error("divider lanes out of step");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (used_r == '0 && !ovf_r && out_valid_r))
    else $error("tick state not cleared on emit");

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for potential_field_repulsion_sum_unit: streams contacts, predicts
// the summed repulsion per tick, and compares every force item. Depends on pfr_pkg.
`timescale 1ns / 1ps

module tb_top;
  import pfr_pkg::*;

  typedef struct {
    logic [15:0] id;
    logic [7:0] team;
    logic signed [31:0] cpos [3];
    logic signed [31:0] spos [3];
    logic last;
  } contact_t;

  typedef struct {
    logic [47:0] frc [3];
    logic sat;
    logic [15:0] used;
  } force_t;

  class repulsion_board;
    longint unsigned radius, min_range, gain;
    bit avoid;
    logic [15:0] own_id;
    logic [7:0] own_team;
    longint signed acc [3];
    bit flag;
    int unsigned used;
    force_t pending [$];
    int errors, ticks, contacts;

    function new();
      radius = 655360; min_range = 327680; avoid = 1;
      own_id = 0; own_team = 0; gain = 256;
      acc[0] = 0; acc[1] = 0; acc[2] = 0; flag = 0; used = 0;
      errors = 0; ticks = 0; contacts = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_RADIUS: radius = v[30:0];
        REG_MIN_RANGE: min_range = v[30:0];
        REG_AVOID: avoid = v[0];
        REG_OWN_ID: own_id = v[15:0];
        REG_OWN_TEAM: own_team = v[7:0];
        REG_GAIN: gain = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [32:0] root_of(logic [65:0] v);
      logic [67:0] rem, trial;
      logic [33:0] root;
      rem = 0; root = 0;
      for (int i = 32; i >= 0; i--) begin
        rem = (rem << 2) | v[2*i +: 2];
        trial = ({34'd0, root} << 2) | 68'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 34'd1;
        end else begin
          root = root << 1;
        end
      end
      return root[32:0];
    endfunction

    function void sat_add(int k, longint signed b);
      longint signed mx, mn, s;
      mx = (64'sd1 <<< 47) - 1;
      mn = -mx - 1;
      s = acc[k] + b;
      if (s > mx) begin
        s = mx; flag = 1;
      end else if (s < mn) begin
        s = mn; flag = 1;
      end
      acc[k] = s;
    endfunction

    function logic [47:0] scale(longint signed s, inout logic sat);
      longint unsigned m, q, rm, r, lim;
      longint signed v;
      lim = 64'd1 << 47;
      m = (s < 0) ? -s : s;
      q = m >> 8; rm = m & 255;
      if (gain != 0 && q > lim / gain) r = lim;
      else r = q * gain + ((rm * gain) >> 8);
      if (s < 0) begin
        if (r > lim) begin
          r = lim; sat = 1;
        end
        v = -longint'(r);
      end else begin
        if (r > lim - 1) begin
          r = lim - 1; sat = 1;
        end
        v = r;
      end
      return v[47:0];
    endfunction

    function void note_contact(contact_t c);
      longint signed d [3];
      longint unsigned a [3], span_v, mag, unit, t;
      logic [65:0] sumsq;
      bit inner;
      force_t f;
      if (c.id != own_id && (avoid || c.team == own_team)) begin
        sumsq = 0;
        for (int i = 0; i < 3; i++) begin
          d[i] = longint'(c.cpos[i]) - longint'(c.spos[i]);
          a[i] = (d[i] < 0) ? -d[i] : d[i];
          sumsq = sumsq + 66'(a[i] * a[i]);
        end
        span_v = root_of(sumsq);
        if (span_v != 0 && span_v <= radius) begin
          inner = !(min_range < span_v);
          mag = 0;
          if (!inner) mag = ((radius - span_v) << 16) / (radius - min_range);
          else flag = 1;
          for (int i = 0; i < 3; i++) begin
            unit = (a[i] << 16) / span_v;
            t = inner ? 64'd10000000000 * unit : (mag * unit) >> 16;
            sat_add(i, d[i] > 0 ? -longint'(t) : longint'(t));
          end
          if (used < 65535) used++;
          contacts++;
        end
      end
      if (c.last) begin
        f.sat = flag;
        for (int i = 0; i < 3; i++) f.frc[i] = scale(acc[i], f.sat);
        f.used = used[15:0];
        pending = {pending, f};
        acc[0] = 0; acc[1] = 0; acc[2] = 0; flag = 0; used = 0;
      end
    endfunction

    function void check_force(force_t got);
      force_t want;
      if (pending.size() == 0) begin
        $display("%0t: force item with nothing expected: x=%h y=%h z=%h", $time,
                 got.frc[0], got.frc[1], got.frc[2]);
        errors++;
        return;
      end
      want = pending.pop_front();
      ticks++;
      for (int i = 0; i < 3; i++)
        if (got.frc[i] !== want.frc[i]) begin
          $display("%0t: force axis %0d expected %h actual %h", $time, i,
                   want.frc[i], got.frc[i]);
          errors++;
        end
      if (got.sat !== want.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
        errors++;
      end
      if (got.used !== want.used) begin
        $display("%0t: contacts_used expected %0d actual %0d", $time, want.used, got.used);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  repulsion_board board = new();
  bit steady;      // no idling on either side while set
  int quiet_cycles;
  longint unsigned rad_now, min_now;

  potential_field_repulsion_sum_unit dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic contact_t unpack_in(logic [IN_W-1:0] d, logic l);
    contact_t c;
    c.id = d[15:0];
    c.team = d[23:16];
    for (int i = 0; i < 3; i++) begin
      c.cpos[i] = d[24 + 32*i +: 32];
      c.spos[i] = d[120 + 32*i +: 32];
    end
    c.last = l;
    return c;
  endfunction

  always @(posedge clk) begin
    force_t f;
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_contact(unpack_in(in_tdata, in_tlast));
      if (out_tvalid && out_tready) begin
        for (int i = 0; i < 3; i++) f.frc[i] = out_tdata[48*i +: 48];
        f.sat = out_tdata[144];
        f.used = out_tdata[160:145];
        board.check_force(f);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      out_tready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  // Stop a hung run: end with a failure when handshakes stop.
  always @(posedge clk)
    if (quiet_cycles > 5000) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("** potential_field_repulsion_sum_unit: FAILED **");
      $finish;
    end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, v);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_config(logic [30:0] r, logic [30:0] m, logic av, logic [15:0] id,
                            logic [7:0] tm, logic [15:0] g);
    drain();
    write_reg(REG_RADIUS, {1'b0, r});
    write_reg(REG_MIN_RANGE, {1'b0, m});
    write_reg(REG_AVOID, {31'd0, av});
    write_reg(REG_OWN_ID, {16'd0, id});
    write_reg(REG_OWN_TEAM, {24'd0, tm});
    write_reg(REG_GAIN, {16'd0, g});
    cfg_valid <= 0;
    rad_now = r;
    min_now = m;
  endtask

  task automatic send(contact_t c);
    logic [IN_W-1:0] d;
    if (!steady && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    d[15:0] = c.id;
    d[23:16] = c.team;
    for (int i = 0; i < 3; i++) begin
      d[24 + 32*i +: 32] = c.cpos[i];
      d[120 + 32*i +: 32] = c.spos[i];
    end
    in_tdata <= d;
    in_tlast <= c.last;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_in();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic contact_t make(logic [15:0] id, logic [7:0] tm, longint dx,
                                    longint dy, longint dz, logic l);
    contact_t c;
    c.id = id; c.team = tm; c.last = l;
    for (int i = 0; i < 3; i++) c.spos[i] = $urandom;
    c.cpos[0] = c.spos[0] + 32'(dx);
    c.cpos[1] = c.spos[1] + 32'(dy);
    c.cpos[2] = c.spos[2] + 32'(dz);
    return c;
  endfunction

  // Offset along each axis sized against the current radii so all bands get hit.
  function automatic longint pick_offset();
    longint span;
    case ($urandom_range(0, 5))
      0: span = 4;
      1: span = min_now / 2 + 1;
      2, 3: span = rad_now / 2 + 1;
      4: span = rad_now + 1;
      default: span = 64'd1 << 31;
    endcase
    if (span > (64'd1 << 31)) span = 64'd1 << 31;
    return longint'($urandom_range(0, 32'(span))) * ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  task automatic random_ticks(int n);
    int sent, len;
    contact_t c;
    logic [15:0] id;
    logic [7:0] tm;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        id = ($urandom_range(0, 9) == 0) ? board.own_id : 16'($urandom);
        tm = ($urandom_range(0, 2) == 0) ? 8'($urandom) : board.own_team;
        if ($urandom_range(0, 15) == 0) begin
          c.id = id; c.team = tm;
          for (int i = 0; i < 3; i++) begin
            c.cpos[i] = $urandom;
            c.spos[i] = $urandom;
          end
        end else begin
          c = make(id, tm, pick_offset(), pick_offset(), pick_offset(), 0);
        end
        c.last = (k == len - 1);
        send(c);
        sent++;
      end
    end
    idle_in();
  endtask

  initial begin
    contact_t c;
    rst_n = 0;
    in_tvalid = 0; in_tlast = 0; in_tdata = '0;
    out_tready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    steady = 0; quiet_cycles = 0;
    rad_now = 655360; min_now = 327680;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: bands, zero distance, skips, last on a skipped contact, extremes.
    send(make(16'd5, 8'd0, 3 * 65536, 0, 0, 0));         // inside minimum range
    send(make(16'd6, 8'd9, 0, -2 * 65536, 65536, 0));    // inside minimum range
    send(make(16'd7, 8'd0, 20 * 65536, 0, 0, 0));        // beyond radius
    send(make(16'd8, 8'd0, 0, 0, 0, 1));                 // zero distance, last
    send(make(16'd0, 8'd0, 65536, 0, 0, 0));             // own id skipped
    send(make(16'd0, 8'd3, 0, 65536, 0, 1));             // last on a skipped contact
    c.id = 16'hFFFF; c.team = 8'hFF; c.last = 0;
    for (int i = 0; i < 3; i++) begin
      c.cpos[i] = 32'h7FFF_FFFF;
      c.spos[i] = 32'h8000_0000;
    end
    send(c);
    c.cpos[0] = 32'h8000_0000; c.spos[0] = 32'h7FFF_FFFF; c.last = 1;
    send(c);
    for (int k = 0; k < 8; k++)                           // pile up huge terms
      send(make(16'd20 + 16'(k), 8'd0, -65536, 0, 0, k == 7));
    idle_in();

    set_config(31'h7FFF_FFFF, 31'd0, 1'b0, 16'hFFFF, 8'hFF, 16'hFFFF);
    send(make(16'd1, 8'hFF, 65536, 65536, 65536, 0));    // same team, kept
    send(make(16'd2, 8'h01, 65536, 0, 0, 0));            // other team skipped
    send(make(16'd3, 8'hFF, 32'h4000_0000, 0, 0, 1));
    idle_in();
    random_ticks(150);

    set_config(31'd655360, 31'd655360, 1'b1, 16'd0, 8'd0, 16'd0);   // radius equals range
    random_ticks(120);
    set_config(31'd65536, 31'd327680, 1'b0, 16'd77, 8'd4, 16'd256); // radius below range
    random_ticks(120);
    set_config(31'd1 << 24, 31'd1 << 20, 1'b1, 16'hFFFF, 8'hFF, 16'd1);
    steady = 1;
    random_ticks(150);
    steady = 0;
    set_config(31'd655360, 31'd327680, 1'b1, 16'd300, 8'd2, 16'd1000);
    random_ticks(150);
    set_config(31'h7FFF_FFFF, 31'h7FFF_FFFE, 1'b1, 16'd0, 8'd0, 16'd65535);
    random_ticks(150);

    drain();
    $display("Covered %0d ticks with %0d contributing contacts over seven register settings.",
             board.ticks, board.contacts);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** potential_field_repulsion_sum_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d force items missing", board.errors, board.pending.size());
      $display("** potential_field_repulsion_sum_unit: FAILED **");
    end
    $finish;
  end
endmodule
